// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define TTE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: name");

// consequent must hold in the cycle after the antecedent
`define TTE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: name");

`endif

// ----- hw/rtl/tte_pkg.sv -----
// types, codes and score helpers of the transposition table engine
`timescale 1ns / 1ps
`default_nettype none
package tte_pkg;

  localparam logic [1:0] ACT_PROBE = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic CFG_PROBE_LIMIT  = 1'b0;
  localparam logic CFG_RECYCLE_BACK = 1'b1;

  localparam logic [3:0] PROBE_LIMIT_RST  = 4'd6;
  localparam logic [3:0] RECYCLE_BACK_RST = 4'd0;

  localparam logic signed [15:0] MATE_EDGE  = 16'sd9000;
  localparam logic signed [15:0] EXACT_BETA = -16'sd20000;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MOD, S_RD, S_CHK, S_RRD, S_RCHK, S_WR, S_CLR, S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0]        check;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic               exact;
  } entry_t;

  typedef struct packed {
    logic ld_in;
    logic mod_step;
    logic rd;
    logic step;
    logic recycle;
    logic wr;
    logic clr_wr;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       mod_last;
    logic       sweep_last;
    logic       walk_more;
    logic       rec_need;
    logic       repl_ok;
    logic       out_free;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // toward_root: probe direction, else store direction
  function automatic logic signed [15:0] mate_adj(input logic signed [15:0] s,
                                                  input logic [7:0] p,
                                                  input logic toward_root);
    logic signed [16:0] s17;
    logic signed [16:0] p17;
    logic signed [15:0] r;
    s17 = {s[15], s};
    p17 = signed'({9'b0, p});
    r = s;
    if (s > MATE_EDGE) begin
      r = toward_root ? sat16(s17 - p17) : sat16(s17 + p17);
    end else if (s < -MATE_EDGE) begin
      r = toward_root ? sat16(s17 + p17) : sat16(s17 - p17);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tte_ctrl.sv -----
// controller state machine of the transposition table engine
`timescale 1ns / 1ps
`default_nettype none
module tte_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  tte_pkg::status_t     status,
  output tte_pkg::cmd_t        cmd
);
  import tte_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: if (status.sweep_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_MOD;
      S_MOD: begin
        if (status.mod_last) begin
          priority if (status.act == ACT_CLEAR) state_next = S_CLR;
          else if (status.act == ACT_PROBE || status.act == ACT_STORE) state_next = S_RD;
          else state_next = S_DONE;
        end
      end
      S_RD:  state_next = S_CHK;
      S_CHK: begin
        priority if (status.walk_more) state_next = S_RD;
        else if (status.act != ACT_STORE) state_next = S_DONE;
        else if (status.rec_need) state_next = S_RRD;
        else if (status.repl_ok) state_next = S_WR;
        else state_next = S_DONE;
      end
      S_RRD:  state_next = S_RCHK;
      S_RCHK: state_next = status.repl_ok ? S_WR : S_DONE;
      S_WR:   state_next = S_DONE;
      S_CLR:  if (status.sweep_last) state_next = S_DONE;
      S_DONE: if (status.out_free) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.ld_in = in_valid;
      end
      S_MOD:  cmd.mod_step = 1'b1;
      S_RD:   cmd.rd = 1'b1;
      S_CHK: begin
        cmd.step    = status.walk_more;
        cmd.recycle = !status.walk_more && status.act == ACT_STORE && status.rec_need;
      end
      S_RRD:  cmd.rd = 1'b1;
      S_RCHK: ;
      S_WR:   cmd.wr = 1'b1;
      S_CLR:  cmd.clr_wr = 1'b1;
      S_DONE: cmd.ld_out = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tte_dp.sv -----
// datapath of the transposition table engine: slot memory, home slot unit, result
`timescale 1ns / 1ps
`default_nettype none
module tte_dp #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_PROBES    = 15
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  tte_pkg::cmd_t           cmd,
  output tte_pkg::status_t        status,
  input  wire logic [1:0]         action,
  input  wire logic               side,
  input  wire logic [31:0]        hash_key,
  input  wire logic [31:0]        board_check,
  input  wire logic [7:0]         search_depth,
  input  wire logic [7:0]         ply,
  input  wire logic signed [15:0] alpha,
  input  wire logic signed [15:0] beta,
  input  wire logic signed [15:0] score_in,
  input  wire logic [15:0]        move_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic [15:0]             move_out,
  output logic                    hit,
  output logic signed [15:0]      alpha_out,
  output logic signed [15:0]      beta_out,
  output logic signed [15:0]      score_out,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data
);
  import tte_pkg::*;

  localparam int SIDE_SLOTS = TABLE_ENTRIES + MAX_PROBES;
  localparam int DEPTH      = 2 * SIDE_SLOTS;
  localparam int AW         = $clog2(DEPTH);
  localparam int LOG_N      = $clog2(TABLE_ENTRIES);
  localparam int RW         = LOG_N + 1;
  localparam int IW         = $clog2(MAX_PROBES + 1);
  localparam int LW         = (IW > 4) ? IW : 4;
  localparam int MOD_CYC    = 3;
  localparam int MCW        = $clog2(MOD_CYC);
  localparam logic [RW-1:0] MODN     = RW'(TABLE_ENTRIES);
  localparam logic [31:0]   MODN32   = 32'(TABLE_ENTRIES);
  localparam logic [63:0]   RECIP64  = (64'd1 << (31 + LOG_N)) / 64'(TABLE_ENTRIES);
  localparam logic [31:0]   RECIP    = RECIP64[31:0];
  localparam logic [AW-1:0] SIDE_OFS = AW'(SIDE_SLOTS);
  localparam logic [LW-1:0] MAXL     = LW'(MAX_PROBES);

  logic [3:0] probe_limit;
  logic [3:0] recycle_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_limit  <= PROBE_LIMIT_RST;
      recycle_back <= RECYCLE_BACK_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PROBE_LIMIT) probe_limit <= cfg_data;
      else recycle_back <= cfg_data;
    end
  end

  // captured transaction
  logic [1:0]         act;
  logic               sd;
  logic [31:0]        hkey;
  logic [31:0]        chk;
  logic [7:0]         dep;
  logic [7:0]         pl;
  logic signed [15:0] a_in;
  logic signed [15:0] b_in;
  logic signed [15:0] s_in;
  logic [15:0]        mv;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      act  <= action;
      sd   <= side;
      hkey <= hash_key;
      chk  <= board_check;
      dep  <= search_depth;
      pl   <= ply;
      a_in <= alpha;
      b_in <= beta;
      s_in <= score_in;
      mv   <= move_in;
    end
  end

  // home slot: reciprocal multiply, back-multiply and subtract, one correction
  logic [31:0]    quot;
  logic [RW-1:0]  rem;
  logic [MCW-1:0] mcnt;
  logic [63:0]    prod;
  logic [31:0]    qn;

  assign prod = {32'd0, hkey} * {32'd0, RECIP};
  assign qn   = quot * MODN32;

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.ld_in) begin
      mcnt <= '0;
    end else if (cmd.mod_step) begin
      mcnt <= mcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_step) begin
      if (mcnt == MCW'(0)) begin
        quot <= 32'(prod >> (31 + LOG_N));
      end else if (mcnt == MCW'(1)) begin
        rem <= RW'(hkey - qn);
      end else begin
        rem <= (rem >= MODN) ? rem - MODN : rem;
      end
    end
  end

  // probe walk
  logic [LW-1:0] limit;
  logic [LW-1:0] idx;
  logic [LW-1:0] rb;
  logic [AW-1:0] base;
  logic [AW-1:0] addr;

  assign limit = (LW'(probe_limit) > MAXL) ? MAXL : LW'(probe_limit);
  assign rb    = LW'(recycle_back);
  assign base  = (sd ? SIDE_OFS : '0) + AW'(rem);
  assign addr  = base + AW'(idx);

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
    end else if (cmd.recycle) begin
      idx <= (rb > idx) ? '0 : idx - rb;
    end
  end

  // slot memory
  entry_t        mem [DEPTH];
  entry_t        rdata;
  entry_t        wentry;
  logic [AW-1:0] sweep;
  logic          sweep_last;
  logic signed [15:0] st_score;
  logic          wrote;

  assign sweep_last = (sweep == AW'(DEPTH - 1));
  assign st_score   = mate_adj(s_in, pl, 1'b0);

  always_comb begin
    wentry.check = chk;
    wentry.depth = dep;
    wentry.score = st_score;
    wentry.move  = mv;
    wentry.exact = !(st_score > b_in);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[sweep] <= '0;
    end else if (cmd.wr) begin
      mem[addr] <= wentry;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.clr_wr) begin
      sweep <= sweep_last ? '0 : sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      wrote <= 1'b0;
    end else if (cmd.wr) begin
      wrote <= 1'b1;
    end
  end

  logic occupied;
  logic other;

  assign occupied = (rdata.depth != 8'd0);
  assign other    = occupied && (rdata.check != chk);

  always_comb begin
    status.act        = act;
    status.mod_last   = (mcnt == MCW'(MOD_CYC - 1));
    status.sweep_last = sweep_last;
    status.walk_more  = (idx < limit) && other;
    status.rec_need   = (idx == limit) && other;
    status.repl_ok    = (dep >= rdata.depth) || (rdata.check != chk);
    status.out_free   = !out_valid || out_ready;
  end

  // result
  logic               p_found;
  logic               p_hit;
  logic signed [15:0] p_score;

  assign p_found = (act == ACT_PROBE) && occupied && (rdata.check == chk);
  assign p_hit   = p_found && (rdata.depth >= dep);
  assign p_score = mate_adj(rdata.score, pl, 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      found     <= p_found;
      move_out  <= p_found ? rdata.move : 16'd0;
      hit       <= (act == ACT_CLEAR) || (act == ACT_STORE && wrote) || p_hit;
      alpha_out <= (p_hit && !rdata.exact && rdata.score > a_in) ?
                   rdata.score - 16'sd1 : a_in;
      beta_out  <= (p_hit && rdata.exact) ? EXACT_BETA : b_in;
      score_out <= (p_hit && rdata.exact) ? p_score : s_in;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/transposition_table_engine_unit.sv -----
// top level of the transposition table engine
`timescale 1ns / 1ps
`default_nettype none
// Two linear-probing position tables (one per side) share one single-port slot
// memory of 2*(TABLE_ENTRIES+MAX_PROBES) entries. After reset the block clears
// every entry of that memory before in_ready rises. Every transaction first
// reduces hash_key to its home slot (reciprocal multiply, back-multiply and
// subtract, one correcting subtract). A probe then reads and checks one slot at
// a time and walks at most probe_limit extra slots, capped at MAX_PROBES; a
// store may add a recycle re-read and the write. A clear sweeps the whole
// memory, one entry a cycle. The result sits in an output register, so the
// next transaction is taken while it waits.
module transposition_table_engine_unit #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_PROBES    = 15
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic               side,
  input  wire logic [31:0]        hash_key,
  input  wire logic [31:0]        board_check,
  input  wire logic [7:0]         search_depth,
  input  wire logic [7:0]         ply,
  input  wire logic signed [15:0] alpha,
  input  wire logic signed [15:0] beta,
  input  wire logic signed [15:0] score_in,
  input  wire logic [15:0]        move_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic [15:0]             move_out,
  output logic                    hit,
  output logic signed [15:0]      alpha_out,
  output logic signed [15:0]      beta_out,
  output logic signed [15:0]      score_out,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data
);
  import tte_pkg::*;

  cmd_t    cmd;
  status_t status;

  tte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tte_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_PROBES    (MAX_PROBES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .action       (action),
    .side         (side),
    .hash_key     (hash_key),
    .board_check  (board_check),
    .search_depth (search_depth),
    .ply          (ply),
    .alpha        (alpha),
    .beta         (beta),
    .score_in     (score_in),
    .move_in      (move_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .move_out     (move_out),
    .hit          (hit),
    .alpha_out    (alpha_out),
    .beta_out     (beta_out),
    .score_out    (score_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/tte_chk.sv -----
// port checker of the transposition table engine and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tte_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        found,
  input wire logic [15:0] move_out,
  input wire logic        hit,
  input wire logic [15:0] score_out
);

  `TTE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TTE_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(found) && $stable(move_out) && $stable(hit) && $stable(score_out))
  `TTE_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `TTE_ASSERT(a_move_zero, clk, rst, !(out_valid && !found) || move_out == 16'd0)

endmodule

bind transposition_table_engine_unit tte_chk u_tte_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .found     (found),
  .move_out  (move_out),
  .hit       (hit),
  .score_out (score_out)
);
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench of the transposition table engine
`timescale 1ns / 1ps
module testbench;
  import tte_pkg::*;

  localparam int ENTRIES = 1024;
  localparam int PROBES  = 15;
  localparam int SIDE_SLOTS = ENTRIES + PROBES;

  typedef struct packed {
    logic [1:0]         action;
    logic               side;
    logic [31:0]        hash_key;
    logic [31:0]        board_check;
    logic [7:0]         search_depth;
    logic [7:0]         ply;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score_in;
    logic [15:0]        move_in;
  } lookup_t;

  typedef struct packed {
    logic               found;
    logic [15:0]        move_out;
    logic               hit;
    logic signed [15:0] alpha_out;
    logic signed [15:0] beta_out;
    logic signed [15:0] score_out;
  } verdict_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] action;
  logic side;
  logic [31:0] hash_key, board_check;
  logic [7:0] search_depth, ply;
  logic signed [15:0] alpha, beta, score_in;
  logic [15:0] move_in;
  logic found, hit;
  logic [15:0] move_out;
  logic signed [15:0] alpha_out, beta_out, score_out;
  logic cfg_we, cfg_index;
  logic [3:0] cfg_data;

  transposition_table_engine_unit u_top (.*);

  logic [31:0] tbl_check [2*SIDE_SLOTS];
  logic [7:0]  tbl_depth [2*SIDE_SLOTS];
  int          tbl_score [2*SIDE_SLOTS];
  logic [15:0] tbl_move  [2*SIDE_SLOTS];
  logic        tbl_exact [2*SIDE_SLOTS];
  int lim_q, back_q;

  lookup_t  pending_q[$];
  verdict_t expected_q[$];
  lookup_t  cur_lookup;
  int send_gap, recv_gap, mismatches, results_seen, items_sent;
  bit quiet;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_score(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int walk_len(int base, logic [31:0] chk);
    int i;
    i = 0;
    while (i < lim_q && tbl_depth[base+i] != 0 && tbl_check[base+i] != chk) i++;
    return i;
  endfunction

  function automatic verdict_t predict_lookup(lookup_t r);
    verdict_t o;
    int base, i, idx, s, a, b, sc;
    o = '0;
    a = r.alpha;
    b = r.beta;
    sc = r.score_in;
    base = r.side * SIDE_SLOTS + r.hash_key[9:0];
    case (r.action)
      ACT_PROBE: begin
        idx = base + walk_len(base, r.board_check);
        if (tbl_depth[idx] != 0 && tbl_check[idx] == r.board_check) begin
          o.found = 1;
          o.move_out = tbl_move[idx];
          if (tbl_depth[idx] >= r.search_depth) begin
            s = tbl_score[idx];
            o.hit = 1;
            if (tbl_exact[idx]) begin
              if (s > 9000) s = clamp_score(s - r.ply);
              else if (s < -9000) s = clamp_score(s + r.ply);
              sc = s;
              b = -20000;
            end else if (s > a) begin
              a = s - 1;
            end
          end
        end
      end
      ACT_STORE: begin
        i = walk_len(base, r.board_check);
        if (i == lim_q && tbl_depth[base+i] != 0 && tbl_check[base+i] != r.board_check)
          i = (back_q > i) ? 0 : i - back_q;
        idx = base + i;
        if (r.search_depth >= tbl_depth[idx] || tbl_check[idx] != r.board_check) begin
          s = r.score_in;
          if (s > 9000) s = clamp_score(s + r.ply);
          else if (s < -9000) s = clamp_score(s - r.ply);
          tbl_check[idx] = r.board_check;
          tbl_depth[idx] = r.search_depth;
          tbl_score[idx] = s;
          tbl_move[idx] = r.move_in;
          tbl_exact[idx] = !(s > b);
          o.hit = 1;
        end
      end
      ACT_CLEAR: begin
        foreach (tbl_depth[k]) tbl_depth[k] = 0;
        o.hit = 1;
      end
      default: ;
    endcase
    o.alpha_out = a[15:0];
    o.beta_out = b[15:0];
    o.score_out = sc[15:0];
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_lookup(cur_lookup));
        items_sent++;
        nv = 0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          cur_lookup = pending_q.pop_front();
          {action, side, hash_key, board_check, search_depth, ply, alpha, beta,
           score_in, move_in} <= cur_lookup;
          nv = 1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end
      end
    end
    in_valid <= nv;
  end

  // monitor
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {found, move_out, hit, alpha_out, beta_out, score_out};
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: expected %p actual %p", results_seen, want, got);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 16);
      end
    end
  end

  function automatic lookup_t make_lookup(logic [1:0] act, logic sd, logic [31:0] key,
                                          logic [31:0] chk, logic [7:0] dep, logic [7:0] pl,
                                          int a, int b, int sc, logic [15:0] mv);
    lookup_t r;
    r.action = act; r.side = sd; r.hash_key = key; r.board_check = chk;
    r.search_depth = dep; r.ply = pl; r.alpha = a[15:0]; r.beta = b[15:0];
    r.score_in = sc[15:0]; r.move_in = mv;
    return r;
  endfunction

  function automatic int pick_score();
    case ($urandom_range(0, 5))
      0: return $urandom_range(8990, 9010);
      1: return -int'($urandom_range(8990, 9010));
      2: return $urandom_range(32500, 32767);
      3: return -int'($urandom_range(32500, 32768));
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic lookup_t random_lookup();
    logic [1:0] act;
    logic [31:0] key, chk;
    int roll;
    roll = $urandom_range(0, 199);
    act = roll < 95 ? ACT_PROBE : roll < 193 ? ACT_STORE : roll < 197 ? 2'd3 : ACT_CLEAR;
    key = $urandom;
    if ($urandom_range(0, 7) != 0)
      key[9:0] = $urandom_range(0, 1) ? 10'($urandom_range(0, 3)) : 10'($urandom_range(1020, 1023));
    chk = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 11);
    return make_lookup(act, $urandom_range(0, 1), key, chk,
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 12),
                       $urandom_range(0, 255), pick_score(), pick_score(), pick_score(),
                       $urandom_range(0, 65535));
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(logic [3:0] lim, logic [3:0] back);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= CFG_PROBE_LIMIT; cfg_data <= lim;
    @(posedge clk);
    cfg_index <= CFG_RECYCLE_BACK; cfg_data <= back;
    @(posedge clk);
    cfg_we <= 0;
    lim_q = lim;
    back_q = back;
  endtask

  initial begin
    int lims[7] = '{15, 0, 3, 1, 15, 8, 5};
    int backs[7] = '{15, 0, 2, 0, 4, 8, 15};
    rst = 1; in_valid = 0; out_ready = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    {action, side, hash_key, board_check, search_depth, ply, alpha, beta, score_in,
     move_in} = '0;
    send_gap = 0; recv_gap = 0; mismatches = 0; results_seen = 0; items_sent = 0;
    quiet = 0; lim_q = PROBE_LIMIT_RST; back_q = RECYCLE_BACK_RST;
    foreach (tbl_depth[k]) begin
      tbl_depth[k] = 0; tbl_check[k] = 0; tbl_score[k] = 0; tbl_move[k] = 0;
      tbl_exact[k] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: exact, mate, bound, depth, side, recycle, unused-action and clear cases
    pending_q.push_back(make_lookup(ACT_STORE, 0, 5, 32'hA, 10, 3, -32768, 32767, 100, 16'h1234));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 5, 32'hA, 10, 3, -32768, 32767, 0, 0));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 5, 32'hA, 11, 3, -5, 5, 7, 0));
    pending_q.push_back(make_lookup(ACT_STORE, 0, 6, 32'hB, 4, 255, 0, 32767, 32767, 16'h0102));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 6, 32'hB, 0, 255, 0, 0, 0, 0));
    pending_q.push_back(make_lookup(ACT_STORE, 0, 7, 32'hC, 4, 255, 0, 32767, -32768, 16'h0304));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 7, 32'hC, 4, 0, 0, 0, 0, 0));
    pending_q.push_back(make_lookup(ACT_STORE, 0, 8, 32'hD, 4, 0, 0, 100, 500, 16'h0506));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 8, 32'hD, 4, 0, 0, 100, 0, 0));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 8, 32'hD, 4, 0, 600, 700, 0, 0));
    pending_q.push_back(make_lookup(ACT_STORE, 0, 9, 32'hE, 0, 0, 0, 0, 1, 16'h0708));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 9, 32'hE, 0, 0, 0, 0, 1, 0));
    pending_q.push_back(make_lookup(2'd3, 1, 5, 32'hA, 1, 1, 1, 1, 1, 1));
    pending_q.push_back(make_lookup(ACT_PROBE, 1, 5, 32'hA, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_lookup(ACT_STORE, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 255, 255,
                                    32767, -32768, -9001, 16'hFFFF));
    pending_q.push_back(make_lookup(ACT_PROBE, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 255, 255,
                                    32767, -32768, 0, 0));
    for (int k = 0; k < 8; k++)
      pending_q.push_back(make_lookup(ACT_STORE, 0, 32'h400, 32'h100 + k, 1, 0, 0, 0, k, k));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 32'h400, 32'h107, 1, 0, -32768, 0, 0, 0));
    pending_q.push_back(make_lookup(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_lookup(ACT_PROBE, 0, 5, 32'hA, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 40; k++) pending_q.push_back(random_lookup());
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(lims[ph], backs[ph]);
      if (ph == 6) quiet = 1;
      for (int k = 0; k < 85; k++) pending_q.push_back(random_lookup());
      drain();
    end

    if (expected_q.size() != 0) mismatches++;
    $display("sent %0d transactions over 8 table settings, %0d results checked, %0d bad",
             items_sent, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6ms;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tte_pkg.sv
hw/rtl/tte_ctrl.sv
hw/rtl/tte_dp.sv
hw/rtl/transposition_table_engine_unit.sv
hw/rtl/tte_chk.sv
bench/testbench.sv
